### rtl/civil_date_day_offset_assert.svh
`ifndef CIVIL_DATE_DAY_OFFSET_ASSERT_SVH
`define CIVIL_DATE_DAY_OFFSET_ASSERT_SVH

// Checks on clk, quiet while rst_n is low.
`define CVD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CVD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

### rtl/cvd_pkg.sv
package cvd_pkg;

  localparam int unsigned DAYS_SHIFT   = 719468;
  localparam int unsigned DAYS_PER_ERA = 146097;
  localparam int unsigned ERA_LAST     = 146096;

  // year bias keeps the shifted year positive; a multiple of 400
  localparam int unsigned YEAR_BIAS = 32800;
  localparam int unsigned DAY_BIAS  = 365 * YEAR_BIAS + YEAR_BIAS / 4 - YEAR_BIAS / 100
                                    + YEAR_BIAS / 400 + DAYS_SHIFT;
  // era bias keeps the shifted day count positive
  localparam int unsigned ERA_BIAS = 16384;
  localparam longint unsigned ZZ_BIAS = longint'(ERA_BIAS) * DAYS_PER_ERA + DAYS_SHIFT;
  localparam int unsigned YEAR_BASE = ERA_BIAS * 400;

  // reciprocals: floor(x/100) = (x*M)>>24 for x < 2**17, etc.
  localparam int unsigned DIV100_MUL  = 167773;
  localparam int unsigned DIVERA_MUL  = 7525901;  // floor(2**40 / 146097)
  localparam int unsigned DIV1460_MUL = 367720;
  localparam int unsigned DIV365_MUL  = 183860;

  localparam int unsigned ZZ_W   = 33;
  localparam int unsigned Q_W    = 15;
  localparam int unsigned DOE_W  = 18;
  localparam int unsigned DAYS_W = 26;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_INPUT  = 2'd1,
    STAT_YEAR_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic signed [15:0] year;
    logic signed [31:0] back;
  } date_t;

  typedef struct packed {
    logic            bad;
    logic [ZZ_W-1:0] zz;
  } days_word_t;

  typedef struct packed {
    logic             bad;
    logic [Q_W-1:0]   q;
    logic [DOE_W-1:0] doe;
  } era_word_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    status_t     status;
  } result_t;

  // first day of year (March based) for each month index
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/cvd_in_if.sv
interface cvd_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         in_day;
  logic [3:0]         in_month;
  logic signed [15:0] in_year;
  logic signed [31:0] days_back;

  modport source (output valid, output in_day, output in_month, output in_year,
                  output days_back, input ready);
  modport sink (input valid, input in_day, input in_month, input in_year,
                input days_back, output ready);
endinterface

### rtl/cvd_out_if.sv
interface cvd_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         out_day;
  logic [3:0]         out_month;
  logic signed [15:0] out_year;
  logic [1:0]         status;

  modport source (output valid, output out_day, output out_month, output out_year,
                  output status, input ready);
  modport sink (input valid, input out_day, input out_month, input out_year,
                input status, output ready);
endinterface

### rtl/cvd_to_days.sv
module cvd_to_days (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cvd_pkg::date_t     in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output cvd_pkg::days_word_t out_word
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: decode, March-based day of year, biased year
  logic        le_feb;
  logic [3:0]  mp;
  logic [17:0] ysum;
  logic        bad1_nxt;
  logic [8:0]  doy1_nxt;
  logic [16:0] yy1_nxt;

  always_comb begin
    le_feb   = in_word.month <= 4'd2;
    mp       = le_feb ? in_word.month + 4'd9 : in_word.month - 4'd3;
    bad1_nxt = (in_word.month == 4'd0) || (in_word.month > 4'd12) || (in_word.day == 5'd0);
    doy1_nxt = cvd_pkg::month_start(mp) + 9'(in_word.day) - 9'd1;
    ysum     = {{2{in_word.year[15]}}, in_word.year} - 18'(le_feb)
             + 18'(cvd_pkg::YEAR_BIAS);
    yy1_nxt  = ysum[16:0];
  end

  logic               bad1_r;
  logic [8:0]         doy1_r;
  logic [16:0]        yy1_r;
  logic signed [31:0] back1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      bad1_r  <= bad1_nxt;
      doy1_r  <= doy1_nxt;
      yy1_r   <= yy1_nxt;
      back1_r <= in_word.back;
    end
  end

  // stage 2: centuries of the biased year
  logic [34:0] c_prod;
  logic [9:0]  q100_nxt;

  always_comb begin
    c_prod   = 35'(yy1_r) * 35'(cvd_pkg::DIV100_MUL);
    q100_nxt = c_prod[33:24];
  end

  logic               bad2_r;
  logic [8:0]         doy2_r;
  logic [16:0]        yy2_r;
  logic [9:0]         q100_2_r;
  logic signed [31:0] back2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      bad2_r   <= bad1_r;
      doy2_r   <= doy1_r;
      yy2_r    <= yy1_r;
      q100_2_r <= q100_nxt;
      back2_r  <= back1_r;
    end
  end

  // stage 3: day number from 1970-01-01, two's complement
  logic [cvd_pkg::DAYS_W-1:0] pos_sum;
  logic [cvd_pkg::DAYS_W-1:0] days3_nxt;

  always_comb begin
    pos_sum   = cvd_pkg::DAYS_W'(yy2_r) * cvd_pkg::DAYS_W'(365)
              + cvd_pkg::DAYS_W'(yy2_r[16:2]) + cvd_pkg::DAYS_W'(q100_2_r[9:2])
              + cvd_pkg::DAYS_W'(doy2_r);
    days3_nxt = pos_sum - cvd_pkg::DAYS_W'(q100_2_r) - cvd_pkg::DAYS_W'(cvd_pkg::DAY_BIAS);
  end

  logic                       bad3_r;
  logic [cvd_pkg::DAYS_W-1:0] days3_r;
  logic signed [31:0]         back3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      bad3_r  <= bad2_r;
      days3_r <= days3_nxt;
      back3_r <= back2_r;
    end
  end

  // stage 4: subtract the offset, shift to a positive era-biased count
  logic [34:0]         zsum;
  cvd_pkg::days_word_t word4_nxt;

  always_comb begin
    zsum = {{(35 - cvd_pkg::DAYS_W){days3_r[cvd_pkg::DAYS_W-1]}}, days3_r}
         - {{3{back3_r[31]}}, back3_r} + 35'(cvd_pkg::ZZ_BIAS);
    word4_nxt.bad = bad3_r;
    word4_nxt.zz  = zsum[cvd_pkg::ZZ_W-1:0];
  end

  cvd_pkg::days_word_t word4_r;

  always_ff @(posedge clk) begin
    if (en4) word4_r <= word4_nxt;
  end

  assign out_valid = v4_r;
  assign out_word  = word4_r;

endmodule

### rtl/cvd_era_split.sv
module cvd_era_split (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cvd_pkg::days_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output cvd_pkg::era_word_t  out_word
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: era estimate from the top bits; equals the era or one less
  logic [47:0]            e_prod;
  logic [cvd_pkg::Q_W-1:0] qe1_nxt;

  always_comb begin
    e_prod  = 48'(in_word.zz[cvd_pkg::ZZ_W-1:8]) * 48'(cvd_pkg::DIVERA_MUL);
    qe1_nxt = e_prod[46:32];
  end

  logic                    bad1_r;
  logic [cvd_pkg::ZZ_W-1:0] zz1_r;
  logic [cvd_pkg::Q_W-1:0]  qe1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      bad1_r <= in_word.bad;
      zz1_r  <= in_word.zz;
      qe1_r  <= qe1_nxt;
    end
  end

  // stage 2: remainder against the estimate, below two eras
  logic [33:0] r_prod;
  logic [32:0] r_diff;
  logic [18:0] rem2_nxt;

  always_comb begin
    r_prod   = 34'(qe1_r) * 34'(cvd_pkg::DAYS_PER_ERA);
    r_diff   = zz1_r - r_prod[32:0];
    rem2_nxt = r_diff[18:0];
  end

  logic                    bad2_r;
  logic [18:0]             rem2_r;
  logic [cvd_pkg::Q_W-1:0] qe2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      bad2_r <= bad1_r;
      rem2_r <= rem2_nxt;
      qe2_r  <= qe1_r;
    end
  end

  // stage 3: one correction step
  logic               over;
  logic [18:0]        rem_fix;
  cvd_pkg::era_word_t word3_nxt;

  always_comb begin
    over          = rem2_r >= 19'(cvd_pkg::DAYS_PER_ERA);
    rem_fix       = over ? rem2_r - 19'(cvd_pkg::DAYS_PER_ERA) : rem2_r;
    word3_nxt.bad = bad2_r;
    word3_nxt.q   = qe2_r + cvd_pkg::Q_W'(over);
    word3_nxt.doe = rem_fix[cvd_pkg::DOE_W-1:0];
  end

  cvd_pkg::era_word_t word3_r;

  always_ff @(posedge clk) begin
    if (en3) word3_r <= word3_nxt;
  end

  assign out_valid = v3_r;
  assign out_word  = word3_r;

endmodule

### rtl/cvd_to_civil.sv
module cvd_to_civil (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cvd_pkg::era_word_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output cvd_pkg::result_t   out_word
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // stage 1: doe / 1460
  logic [36:0] p_prod;
  logic [6:0]  p1460_nxt;

  always_comb begin
    p_prod    = 37'(in_word.doe) * 37'(cvd_pkg::DIV1460_MUL);
    p1460_nxt = p_prod[35:29];
  end

  logic                      bad1_r;
  logic [cvd_pkg::Q_W-1:0]   q1_r;
  logic [cvd_pkg::DOE_W-1:0] doe1_r;
  logic [6:0]                p1460_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      bad1_r  <= in_word.bad;
      q1_r    <= in_word.q;
      doe1_r  <= in_word.doe;
      p1460_r <= p1460_nxt;
    end
  end

  // stage 2: leap-day corrected day count of the era
  logic [2:0]                cent;
  logic                      era_end;
  logic [cvd_pkg::DOE_W-1:0] n2_nxt;

  always_comb begin
    cent    = 3'(doe1_r >= 18'd36524) + 3'(doe1_r >= 18'd73048)
            + 3'(doe1_r >= 18'd109572) + 3'(doe1_r >= 18'(cvd_pkg::ERA_LAST));
    era_end = doe1_r == 18'(cvd_pkg::ERA_LAST);
    n2_nxt  = doe1_r - 18'(p1460_r) + 18'(cent) - 18'(era_end);
  end

  logic                      bad2_r;
  logic [cvd_pkg::Q_W-1:0]   q2_r;
  logic [cvd_pkg::DOE_W-1:0] doe2_r;
  logic [cvd_pkg::DOE_W-1:0] n2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      bad2_r <= bad1_r;
      q2_r   <= q1_r;
      doe2_r <= doe1_r;
      n2_r   <= n2_nxt;
    end
  end

  // stage 3: year of era
  logic [35:0] y_prod;
  logic [8:0]  yoe3_nxt;

  always_comb begin
    y_prod   = 36'(n2_r) * 36'(cvd_pkg::DIV365_MUL);
    yoe3_nxt = y_prod[34:26];
  end

  logic                      bad3_r;
  logic [cvd_pkg::Q_W-1:0]   q3_r;
  logic [cvd_pkg::DOE_W-1:0] doe3_r;
  logic [8:0]                yoe3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      bad3_r <= bad2_r;
      q3_r   <= q2_r;
      doe3_r <= doe2_r;
      yoe3_r <= yoe3_nxt;
    end
  end

  // stage 4: day of year and March-based year
  logic [cvd_pkg::DOE_W-1:0]  ystart;
  logic [cvd_pkg::DOE_W-1:0]  doy_full;
  logic [cvd_pkg::DAYS_W-1:0] year4_nxt;

  always_comb begin
    ystart    = 18'(yoe3_r) * 18'(365) + 18'(yoe3_r[8:2])
              - 18'(yoe3_r >= 9'd100) - 18'(yoe3_r >= 9'd200) - 18'(yoe3_r >= 9'd300);
    doy_full  = doe3_r - ystart;
    year4_nxt = cvd_pkg::DAYS_W'(yoe3_r) + cvd_pkg::DAYS_W'(q3_r) * cvd_pkg::DAYS_W'(400)
              - cvd_pkg::DAYS_W'(cvd_pkg::YEAR_BASE);
  end

  logic                       bad4_r;
  logic [8:0]                 doy4_r;
  logic [cvd_pkg::DAYS_W-1:0] year4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      bad4_r  <= bad3_r;
      doy4_r  <= doy_full[8:0];
      year4_r <= year4_nxt;
    end
  end

  // stage 5: month lookup, calendar year, range check, output register
  logic [3:0]                 mp;
  logic [8:0]                 day_off;
  logic [cvd_pkg::DAYS_W-1:0] year_cal;
  logic                       in_range;
  cvd_pkg::result_t           res_nxt;

  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy4_r >= cvd_pkg::month_start(4'(i))) mp = 4'(i);
    end
    day_off  = doy4_r - cvd_pkg::month_start(mp) + 9'd1;
    year_cal = year4_r + cvd_pkg::DAYS_W'(mp >= 4'd10);
    // fits 16 bits when everything above bit 15 repeats the sign
    in_range = (year_cal[cvd_pkg::DAYS_W-1:15] == '0) ||
               (year_cal[cvd_pkg::DAYS_W-1:15] == '1);

    res_nxt.day    = day_off[4:0];
    res_nxt.month  = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    res_nxt.year   = in_range ? year_cal[15:0] : 16'd0;
    res_nxt.status = in_range ? cvd_pkg::STAT_OK : cvd_pkg::STAT_YEAR_RANGE;
    if (bad4_r) begin
      res_nxt.day    = 5'd0;
      res_nxt.month  = 4'd0;
      res_nxt.year   = 16'd0;
      res_nxt.status = cvd_pkg::STAT_BAD_INPUT;
    end
  end

  cvd_pkg::result_t res_r;

  always_ff @(posedge clk) begin
    if (en5) res_r <= res_nxt;
  end

  assign out_valid = v5_r;
  assign out_word  = res_r;

endmodule

### rtl/civil_date_day_offset.sv
// Accepted input words pass through all pipeline stages, in order, to out_ch.
// Throughput: one word per cycle while out_ch is ready; each stage has a valid
// bit, so bubbles close up and a stalled output holds while upstream stages keep filling.
// Depth is set by the four constant-reciprocal multipliers and the era split.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`include "civil_date_day_offset_assert.svh"

module civil_date_day_offset (
  input  logic     clk,
  input  logic     rst_n,
  cvd_in_if.sink   in_ch,
  cvd_out_if.source out_ch
);

  cvd_pkg::date_t      date_word;
  cvd_pkg::days_word_t days_word;
  cvd_pkg::era_word_t  era_word;
  cvd_pkg::result_t    res_word;

  logic days_valid, days_ready;
  logic era_valid, era_ready;

  always_comb begin
    date_word.day   = in_ch.in_day;
    date_word.month = in_ch.in_month;
    date_word.year  = in_ch.in_year;
    date_word.back  = in_ch.days_back;
  end

  cvd_to_days u_to_days (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word   (date_word),
    .out_valid (days_valid),
    .out_ready (days_ready),
    .out_word  (days_word)
  );

  cvd_era_split u_era_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (days_valid),
    .in_ready  (days_ready),
    .in_word   (days_word),
    .out_valid (era_valid),
    .out_ready (era_ready),
    .out_word  (era_word)
  );

  cvd_to_civil u_to_civil (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (era_valid),
    .in_ready  (era_ready),
    .in_word   (era_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (res_word)
  );

  assign out_ch.out_day   = res_word.day;
  assign out_ch.out_month = res_word.month;
  assign out_ch.out_year  = res_word.year;
  assign out_ch.status    = res_word.status;

  `CVD_ASSERT_IMPL(a_bad_word_zero,
    out_ch.valid && (out_ch.status == cvd_pkg::STAT_BAD_INPUT),
    (out_ch.out_day == 5'd0) && (out_ch.out_month == 4'd0) && (out_ch.out_year == 16'sd0),
    "bad-input word carries nonzero date")
  `CVD_ASSERT_IMPL(a_range_word,
    out_ch.valid && (out_ch.status == cvd_pkg::STAT_YEAR_RANGE),
    (out_ch.out_year == 16'sd0) && (out_ch.out_month >= 4'd1) && (out_ch.out_month <= 4'd12),
    "out-of-range word malformed")
  `CVD_ASSERT_NEVER(a_ok_date_legal,
    out_ch.valid && (out_ch.status == cvd_pkg::STAT_OK) &&
    ((out_ch.out_day == 5'd0) || (out_ch.out_month == 4'd0) || (out_ch.out_month > 4'd12)),
    "ok word with illegal day or month")
  `CVD_ASSERT_IMPL(a_empty_out_ready, !out_ch.valid, in_ch.ready,
    "input stalled while output stage is empty")

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Expected-result store for the date shifter: one expectation per accepted word.
class shifted_date_ledger;
  localparam longint ERA_DAYS    = 146097;   // 400 Gregorian years
  localparam longint ERA_TAIL    = 146096;
  localparam longint YEAR_MIN    = -32768;
  localparam longint YEAR_MAX    = 32767;

  cvd_pkg::result_t awaiting[$];
  int unsigned      failures;

  function cvd_pkg::result_t shift_civil_date(cvd_pkg::date_t d);
    longint           y, m, dd, era, yoe, mp, doy, doe, z;
    cvd_pkg::result_t r;
    r = '0;
    if (d.month < 1 || d.month > 12 || d.day == 0) begin
      r.status = cvd_pkg::STAT_BAD_INPUT;
      return r;
    end
    y  = longint'($signed(d.year));
    m  = longint'(d.month);
    dd = longint'(d.day);
    // March-based year: Jan/Feb belong to the previous year
    if (m <= 2) y -= 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + dd - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    z   = era * ERA_DAYS + doe - longint'($signed(d.back));

    // back to a civil date; z is already shifted by the epoch offset
    era = (z >= 0 ? z : z - ERA_TAIL) / ERA_DAYS;
    doe = z - era * ERA_DAYS;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / ERA_TAIL) / 365;
    y   = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dd  = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    if (m <= 2) y += 1;

    r.day   = dd[4:0];
    r.month = m[3:0];
    if (y < YEAR_MIN || y > YEAR_MAX) begin
      r.status = cvd_pkg::STAT_YEAR_RANGE;
    end else begin
      r.year   = y[15:0];
      r.status = cvd_pkg::STAT_OK;
    end
    return r;
  endfunction

  function void note_date(cvd_pkg::date_t d);
    awaiting.push_back(shift_civil_date(d));
  endfunction

  function void check_shifted(cvd_pkg::result_t got);
    cvd_pkg::result_t want;
    if (awaiting.size() == 0) begin
      $error("result word with no expectation: day %0d month %0d year %0d status %0d",
             got.day, got.month, $signed(got.year), got.status);
      failures++;
      return;
    end
    want = awaiting.pop_front();
    if (got.day !== want.day) begin
      $error("out_day: expected %0d, got %0d", want.day, got.day);
      failures++;
    end
    if (got.month !== want.month) begin
      $error("out_month: expected %0d, got %0d", want.month, got.month);
      failures++;
    end
    if (got.year !== want.year) begin
      $error("out_year: expected %0d, got %0d", $signed(want.year), $signed(got.year));
      failures++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failures++;
    end
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_WORDS    = 210;

  logic clk = 1'b0;
  logic rst_n;

  cvd_in_if  in_ch ();
  cvd_out_if out_ch ();

  civil_date_day_offset dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  shifted_date_ledger ledger = new();

  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;

  always #2 clk = ~clk;

  // receiver: ready re-rolled every falling edge
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        ledger.note_date('{in_ch.in_day, in_ch.in_month, in_ch.in_year, in_ch.days_back});
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        ledger.check_shifted('{out_ch.out_day, out_ch.out_month, out_ch.out_year,
                               cvd_pkg::status_t'(out_ch.status)});
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_date(input cvd_pkg::date_t d);
    bit shown = 0;
    while (!shown) begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid = 1'b0;
      end else begin
        in_ch.valid     = 1'b1;
        in_ch.in_day    = d.day;
        in_ch.in_month  = d.month;
        in_ch.in_year   = d.year;
        in_ch.days_back = d.back;
        shown = 1;
      end
    end
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold valid low until every outstanding word has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (ledger.awaiting.size() != 0) @(posedge clk);
  endtask

  function automatic cvd_pkg::date_t random_date();
    cvd_pkg::date_t d;
    int             pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      // noise: any bit pattern, many of them bad inputs
      d.day   = 5'($urandom);
      d.month = 4'($urandom);
      d.year  = 16'($urandom);
      d.back  = $urandom;
      return d;
    end
    d.day   = 5'(($urandom_range(3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28));
    d.month = 4'($urandom_range(1, 12));
    case ($urandom_range(3))
      0:       d.year = 16'($urandom);
      1:       d.year = 16'(1600 + $urandom_range(800));
      2:       d.year = 16'($urandom_range(1) ? 32'h7FFF - $urandom_range(3)
                                              : 32'h8000 + $urandom_range(3));
      default: d.year = 16'(int'($urandom_range(800)) - 400);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: d.back = int'($urandom_range(800)) - 400;
      4, 5, 6:    d.back = int'($urandom_range(2000000)) - 1000000;
      7:          d.back = ($urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(50)
                                              : 32'sh8000_0000 + $urandom_range(50));
      default:    d.back = $urandom;
    endcase
    return d;
  endfunction

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.in_day    = '0;
    in_ch.in_month  = '0;
    in_ch.in_year   = '0;
    in_ch.days_back = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words, no idling
    send_date('{5'd1,  4'd1,  16'sd1970, 32'sd0});
    send_date('{5'd0,  4'd1,  16'sd2000, 32'sd0});          // day zero
    send_date('{5'd15, 4'd0,  16'sd2000, 32'sd0});          // month zero
    send_date('{5'd15, 4'd13, 16'sd2000, 32'sd0});          // month past December
    send_date('{5'd31, 4'd15, 16'shFFFF, 32'shFFFF_FFFF});  // all ones, bad month
    send_date('{5'd31, 4'd2,  16'sd2023, 32'sd0});          // rolls into March
    send_date('{5'd30, 4'd2,  16'sd2024, 32'sd0});
    send_date('{5'd29, 4'd2,  16'sd2000, -32'sd1});
    send_date('{5'd1,  4'd3,  16'sd1900, 32'sd1});
    send_date('{5'd29, 4'd2,  16'sd0,    32'sd0});
    send_date('{5'd31, 4'd12, 16'sd1969, -32'sd1});
    send_date('{5'd31, 4'd12, 16'sh7FFF, 32'sd0});
    send_date('{5'd31, 4'd12, 16'sh7FFF, -32'sd1});          // year overflows upward
    send_date('{5'd1,  4'd1,  16'sh8000, 32'sd0});
    send_date('{5'd1,  4'd1,  16'sh8000, 32'sd1});           // year overflows downward
    send_date('{5'd1,  4'd3,  -16'sd1,   32'sd366});
    send_date('{5'd15, 4'd6,  16'sd2000, 32'sh7FFF_FFFF});
    send_date('{5'd15, 4'd6,  16'sd2000, 32'sh8000_0000});
    send_date('{5'd1,  4'd1,  16'sh8000, 32'sh7FFF_FFFF});
    send_date('{5'd31, 4'd12, 16'sh7FFF, 32'sh8000_0000});
    send_date('{5'd28, 4'd2,  16'sd2100, -32'sd1});
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin send_idle_pct = 61; sink_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_stall_pct = 61; end
        default: begin send_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      repeat (PHASE_WORDS) send_date(random_date());
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.failures == 0 && ledger.awaiting.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
